// ----- hdl/cci_pkg.sv -----
`default_nettype none

package cci_pkg;

  // Field width of every coordinate, radius and distance
  localparam int FW       = 16;
  // Quotient magnitude bits; larger magnitudes clamp to 2**QW
  localparam int QW       = 17;
  // Signed quotient width (clamped magnitude plus sign)
  localparam int QOW      = QW + 2;
  // Divider numerator (signed) and working remainder widths
  localparam int NW       = 39;
  localparam int MW       = 40;
  // Divider divisor width
  localparam int DW       = 17;
  // Divider latency: entry stage, one stage per quotient bit, output stage
  localparam int DIV_LAT  = QW + 2;
  // Square root: radicand width, result bits, remainder width
  localparam int RAD_W    = 32;
  localparam int SQ_STEPS = 16;
  localparam int SQ_RW    = 20;

  // Geometry carried beside the arithmetic
  typedef struct packed {
    logic signed [FW-1:0] ax;
    logic signed [FW-1:0] ay;
    logic signed [FW:0]   dx;
    logic signed [FW:0]   dy;
    logic [FW-1:0]        d;
    logic                 miss;
  } geo_t;

  // Geometry plus the squared first radius, alongside the chord divide
  typedef struct packed {
    geo_t            geo;
    logic [RAD_W-1:0] ra2;
  } chord_side_t;

  // Geometry plus the chord foot, alongside the square root
  typedef struct packed {
    geo_t                  geo;
    logic signed [QOW-1:0] a;
  } root_side_t;

  // Centre and miss flag, alongside the offset divides
  typedef struct packed {
    logic signed [FW-1:0] ax;
    logic signed [FW-1:0] ay;
    logic                 miss;
  } out_side_t;

  // One square root stage
  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [SQ_RW-1:0]    rem;
    logic [SQ_STEPS-1:0] root;
  } sq_stage_t;

  // One divider stage
  typedef struct packed {
    logic [MW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_stage_t;

  // Clamp a widened coordinate to the signed field range
  function automatic logic signed [FW-1:0] sat16(input logic signed [FW+3:0] v);
    logic signed [FW+3:0] hi;
    logic signed [FW+3:0] lo;
    hi = (FW+4)'(32767);
    lo = -(FW+4)'(32768);
    if (v > hi) begin
      sat16 = FW'(hi);
    end else if (v < lo) begin
      sat16 = FW'(lo);
    end else begin
      sat16 = v[FW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cci_div.sv -----
`default_nettype none

module cci_div (
  input  wire logic                           clk,
  input  wire logic signed [cci_pkg::NW-1:0]  num,
  input  wire logic [cci_pkg::DW-1:0]         den,
  output logic signed [cci_pkg::QOW-1:0]      quo
);

  cci_pkg::div_stage_t st_r   [cci_pkg::QW+1];
  cci_pkg::div_stage_t st_nxt [cci_pkg::QW+1];

  logic signed [cci_pkg::MW-1:0] num_ext;
  logic [cci_pkg::MW-1:0]        mag;
  logic [cci_pkg::QW:0]          qmag;
  logic signed [cci_pkg::QOW-1:0] quo_nxt;

  // Take magnitude, add half the divisor for rounding, flag clamped quotients
  always_comb begin
    num_ext = cci_pkg::MW'(num);
    mag = num_ext[cci_pkg::MW-1] ? cci_pkg::MW'(-num_ext) : cci_pkg::MW'(num_ext);
    st_nxt[0].rem = mag + cci_pkg::MW'(den >> 1);
    st_nxt[0].den = den;
    st_nxt[0].quo = '0;
    st_nxt[0].neg = num_ext[cci_pkg::MW-1];
    st_nxt[0].ovf = (st_nxt[0].rem >= (cci_pkg::MW'(den) << cci_pkg::QW));
  end

  // Restoring division, one quotient bit per stage, top bit first
  for (genvar k = 0; k < cci_pkg::QW; k++) begin : g_step
    logic [cci_pkg::MW-1:0] shd;
    always_comb begin
      shd = cci_pkg::MW'(st_r[k].den) << (cci_pkg::QW - 1 - k);
      st_nxt[k+1] = st_r[k];
      if (st_r[k].rem >= shd) begin
        st_nxt[k+1].rem = st_r[k].rem - shd;
        st_nxt[k+1].quo[cci_pkg::QW-1-k] = 1'b1;
      end
    end
  end

  // Clamp and restore sign
  always_comb begin
    qmag = st_r[cci_pkg::QW].ovf ? (cci_pkg::QW+1)'(1) << cci_pkg::QW
                                  : {1'b0, st_r[cci_pkg::QW].quo};
    quo_nxt = st_r[cci_pkg::QW].neg ? -cci_pkg::QOW'(qmag) : cci_pkg::QOW'(qmag);
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    for (int i = 0; i <= cci_pkg::QW; i++) begin
      st_r[i] <= st_nxt[i];
    end
    quo <= quo_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/circle_circle_intersection.sv -----
`default_nettype none

// Two-circle intersection points, signed/unsigned Q8.8 metres.
// Input channel: a beat is taken at each rising edge with start high and busy
// low. busy is always low, so a new circle pair may enter every cycle.
// The pair is two centres, two radii and the caller's centre distance.
// Result channel: out_valid is high for exactly one cycle per input beat and
// carries found plus the two points. If the circles miss (distance above the
// radius sum, below the radius difference, or zero) found is 0 and all
// coordinates are 0. Tangent circles give two equal points.
// Throughput is one beat per cycle. The depth is set by two 19-stage
// bit-per-stage dividers (chord foot, then the four offsets in parallel)
// and a 16-stage square root.
// Results come out in input order. The receiver cannot stall the block.
// Reset (rst_n low, synchronous) clears all valid bits, so no result beats
// appear for items in flight; data registers are not reset.
module circle_circle_intersection (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [cci_pkg::FW-1:0] in_center_a_x,
  input  wire logic signed [cci_pkg::FW-1:0] in_center_a_y,
  input  wire logic signed [cci_pkg::FW-1:0] in_center_b_x,
  input  wire logic signed [cci_pkg::FW-1:0] in_center_b_y,
  input  wire logic [cci_pkg::FW-1:0]        in_radius_a,
  input  wire logic [cci_pkg::FW-1:0]        in_radius_b,
  input  wire logic [cci_pkg::FW-1:0]        in_center_distance,
  output logic                               out_valid,
  output logic                               out_found,
  output logic signed [cci_pkg::FW-1:0]      out_first_x,
  output logic signed [cci_pkg::FW-1:0]      out_first_y,
  output logic signed [cci_pkg::FW-1:0]      out_second_x,
  output logic signed [cci_pkg::FW-1:0]      out_second_y
);

  localparam int FW = cci_pkg::FW;
  localparam int DL = cci_pkg::DIV_LAT;
  localparam int SS = cci_pkg::SQ_STEPS;

  assign busy = 1'b0;

  // ---------------- stage 1: capture inputs ----------------
  logic                 v1_r;
  logic signed [FW-1:0] ax1_r, ay1_r, bx1_r, by1_r;
  logic [FW-1:0]        ra1_r, rb1_r, d1_r;

  always_ff @(posedge clk) begin
    ax1_r <= in_center_a_x;
    ay1_r <= in_center_a_y;
    bx1_r <= in_center_b_x;
    by1_r <= in_center_b_y;
    ra1_r <= in_radius_a;
    rb1_r <= in_radius_b;
    d1_r  <= in_center_distance;
  end

  // ---------------- stage 2: squares, miss test, deltas ----------------
  logic                       v2_r;
  logic [2*FW-1:0]            ra2_2_r, rb2_2_r, dd2_r;
  cci_pkg::geo_t              geo2_r, geo2_nxt;
  logic [FW-1:0]              rdiff;
  logic [FW:0]                rsum;

  always_comb begin
    rdiff = (ra1_r > rb1_r) ? ra1_r - rb1_r : rb1_r - ra1_r;
    rsum  = {1'b0, ra1_r} + {1'b0, rb1_r};
    geo2_nxt.ax   = ax1_r;
    geo2_nxt.ay   = ay1_r;
    geo2_nxt.dx   = (FW+1)'(bx1_r) - (FW+1)'(ax1_r);
    geo2_nxt.dy   = (FW+1)'(by1_r) - (FW+1)'(ay1_r);
    geo2_nxt.d    = d1_r;
    geo2_nxt.miss = (d1_r == '0) || ({1'b0, d1_r} > rsum) || (d1_r < rdiff);
  end

  always_ff @(posedge clk) begin
    ra2_2_r <= ra1_r * ra1_r;
    rb2_2_r <= rb1_r * rb1_r;
    dd2_r   <= d1_r * d1_r;
    geo2_r  <= geo2_nxt;
  end

  // ---------------- stage 3: chord-foot numerator ----------------
  logic                          v3_r;
  logic signed [2*FW+1:0]        num3_r;
  cci_pkg::chord_side_t          side3_r;

  always_ff @(posedge clk) begin
    num3_r <= $signed({2'b00, ra2_2_r}) - $signed({2'b00, rb2_2_r})
            + $signed({2'b00, dd2_r});
    side3_r.geo <= geo2_r;
    side3_r.ra2 <= ra2_2_r;
  end

  // ---------------- chord foot a = num / (2 d) ----------------
  logic signed [cci_pkg::QOW-1:0] a_q;
  cci_pkg::chord_side_t           cd_r [DL];
  logic [DL-1:0]                  vcd_r;

  cci_div u_div_a (
    .clk (clk),
    .num (cci_pkg::NW'(num3_r)),
    .den ({side3_r.geo.d, 1'b0}),
    .quo (a_q)
  );

  // Hold the side data for the divider depth
  always_ff @(posedge clk) begin
    cd_r[0] <= side3_r;
    for (int i = 1; i < DL; i++) begin
      cd_r[i] <= cd_r[i-1];
    end
  end

  // ---------------- half-chord radicand, square root ----------------
  localparam int MWH = cci_pkg::RAD_W + 8;
  logic signed [2*cci_pkg::QOW-1:0] asq;
  logic signed [MWH-1:0]            h2_s;
  cci_pkg::sq_stage_t  sq_r   [SS+1];
  cci_pkg::sq_stage_t  sq_nxt [SS+1];
  cci_pkg::root_side_t rs_r   [SS+1];
  logic [SS:0]         vs_r;

  always_comb begin
    asq  = a_q * a_q;
    h2_s = $signed({8'd0, cd_r[DL-1].ra2}) - MWH'(asq);
    sq_nxt[0].rad  = h2_s[MWH-1] ? '0 : h2_s[cci_pkg::RAD_W-1:0];
    sq_nxt[0].rem  = '0;
    sq_nxt[0].root = '0;
  end

  // Two radicand bits per stage, one root bit per stage
  for (genvar k = 0; k < SS; k++) begin : g_sq
    logic [cci_pkg::SQ_RW-1:0] rem2;
    logic [cci_pkg::SQ_RW-1:0] trial;
    always_comb begin
      rem2  = {sq_r[k].rem[cci_pkg::SQ_RW-3:0], sq_r[k].rad[2*(SS-1-k)+1 -: 2]};
      trial = cci_pkg::SQ_RW'({sq_r[k].root, 2'b01});
      sq_nxt[k+1].rad = sq_r[k].rad;
      if (rem2 >= trial) begin
        sq_nxt[k+1].rem  = rem2 - trial;
        sq_nxt[k+1].root = {sq_r[k].root[SS-2:0], 1'b1};
      end else begin
        sq_nxt[k+1].rem  = rem2;
        sq_nxt[k+1].root = {sq_r[k].root[SS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= SS; i++) begin
      sq_r[i] <= sq_nxt[i];
    end
    rs_r[0].geo <= cd_r[DL-1].geo;
    rs_r[0].a   <= a_q;
    for (int i = 1; i <= SS; i++) begin
      rs_r[i] <= rs_r[i-1];
    end
  end

  // ---------------- products ----------------
  logic                       vp_r;
  logic signed [FW:0]         h_s;
  logic signed [cci_pkg::QOW+FW:0] adx_r, ady_r;
  logic signed [2*FW+1:0]     hdx_r, hdy_r;
  cci_pkg::out_side_t         ps_r;
  logic [FW-1:0]              dp_r;

  assign h_s = $signed({1'b0, sq_r[SS].root});

  always_ff @(posedge clk) begin
    adx_r <= rs_r[SS].a * rs_r[SS].geo.dx;
    ady_r <= rs_r[SS].a * rs_r[SS].geo.dy;
    hdx_r <= h_s * rs_r[SS].geo.dx;
    hdy_r <= h_s * rs_r[SS].geo.dy;
    ps_r.ax   <= rs_r[SS].geo.ax;
    ps_r.ay   <= rs_r[SS].geo.ay;
    ps_r.miss <= rs_r[SS].geo.miss;
    dp_r      <= rs_r[SS].geo.d;
  end

  // ---------------- offset numerators ----------------
  logic                            vn_r;
  logic signed [cci_pkg::NW-1:0]   n1_r, n2_r, n3_r, n4_r;
  cci_pkg::out_side_t              ns_r;
  logic [FW-1:0]                   dn_r;

  always_ff @(posedge clk) begin
    n1_r <= cci_pkg::NW'(adx_r) + cci_pkg::NW'(hdy_r);
    n2_r <= cci_pkg::NW'(ady_r) - cci_pkg::NW'(hdx_r);
    n3_r <= cci_pkg::NW'(adx_r) - cci_pkg::NW'(hdy_r);
    n4_r <= cci_pkg::NW'(ady_r) + cci_pkg::NW'(hdx_r);
    ns_r <= ps_r;
    dn_r <= dp_r;
  end

  // ---------------- offset divides ----------------
  logic signed [cci_pkg::QOW-1:0] q1, q2, q3, q4;
  cci_pkg::out_side_t             os_r [DL];
  logic [DL-1:0]                  vo_r;

  cci_div u_div_1 (.clk(clk), .num(n1_r), .den({1'b0, dn_r}), .quo(q1));
  cci_div u_div_2 (.clk(clk), .num(n2_r), .den({1'b0, dn_r}), .quo(q2));
  cci_div u_div_3 (.clk(clk), .num(n3_r), .den({1'b0, dn_r}), .quo(q3));
  cci_div u_div_4 (.clk(clk), .num(n4_r), .den({1'b0, dn_r}), .quo(q4));

  always_ff @(posedge clk) begin
    os_r[0] <= ns_r;
    for (int i = 1; i < DL; i++) begin
      os_r[i] <= os_r[i-1];
    end
  end

  // ---------------- add centre, saturate, drive result ----------------
  cci_pkg::out_side_t  fin;
  assign fin = os_r[DL-1];

  always_ff @(posedge clk) begin
    if (fin.miss) begin
      out_found    <= 1'b0;
      out_first_x  <= '0;
      out_first_y  <= '0;
      out_second_x <= '0;
      out_second_y <= '0;
    end else begin
      out_found    <= 1'b1;
      out_first_x  <= cci_pkg::sat16((FW+4)'(fin.ax) + (FW+4)'(q1));
      out_first_y  <= cci_pkg::sat16((FW+4)'(fin.ay) + (FW+4)'(q2));
      out_second_x <= cci_pkg::sat16((FW+4)'(fin.ax) + (FW+4)'(q3));
      out_second_y <= cci_pkg::sat16((FW+4)'(fin.ay) + (FW+4)'(q4));
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      vcd_r     <= '0;
      vs_r      <= '0;
      vp_r      <= 1'b0;
      vn_r      <= 1'b0;
      vo_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= start && !busy;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      vcd_r     <= {vcd_r[DL-2:0], v3_r};
      vs_r      <= {vs_r[SS-1:0], vcd_r[DL-1]};
      vp_r      <= vs_r[SS];
      vn_r      <= vp_r;
      vo_r      <= {vo_r[DL-2:0], vn_r};
      out_valid <= vo_r[DL-1];
    end
  end

  // ---------------- assertions ----------------
  // A missed pair reports all-zero points
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_first_x == '0 && out_first_y == '0 && out_second_x == '0 && out_second_y == '0))
    else $error("miss result carries nonzero points");

  // The chord foot never clamps for an intersecting pair
  a_chord_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vcd_r[DL-1] && !cd_r[DL-1].geo.miss) |->
      (a_q != -(cci_pkg::QOW'(1) << cci_pkg::QW) && a_q != (cci_pkg::QOW'(1) << cci_pkg::QW)))
    else $error("chord foot out of range");

  // Square root result is the floor root of its radicand
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r[SS] |->
      ((34'(sq_r[SS].root) * 34'(sq_r[SS].root) <= 34'(sq_r[SS].rad)) &&
       ((34'(sq_r[SS].root) + 34'd1) * (34'(sq_r[SS].root) + 34'd1) > 34'(sq_r[SS].rad))))
    else $error("square root not floor");

  // Every beat leaving the offset divides reaches the result port
  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r[DL-1] |=> out_valid)
    else $error("result beat lost at output");

endmodule

`default_nettype wire
